// ----- rtl/mer_pkg.sv -----
// ----------------------------------------------------------------------------
// mer_pkg - shared types and constants for the midpoint ellipse rasteriser
// Field widths, internal arithmetic widths, controller states, datapath
// operation codes and the status bundle returned by the datapath.
// ----------------------------------------------------------------------------
package mer_pkg;

  // Field widths
  localparam int AXIS_BITS  = 9;
  localparam int COORD_BITS = 10;
  localparam int OUT_BITS   = 12;
  localparam int COLOR_BITS = 4;

  // Internal widths, all follow from the semi-axis width
  localparam int X_BITS   = AXIS_BITS + 1;        // x may run a little past a
  localparam int Y_BITS   = AXIS_BITS + 1;
  localparam int TX_BITS  = X_BITS + 1;           // 2x+1
  localparam int SQ_BITS  = 2 * AXIS_BITS;        // a^2, b^2
  localparam int XY_BITS  = 3 * AXIS_BITS + 1;    // b^2*x, a^2*y
  localparam int MA_BITS  = 3 * AXIS_BITS + 2;    // multiplier port A
  localparam int MB_BITS  = 2 * AXIS_BITS;        // multiplier port B
  localparam int P_BITS   = MA_BITS + MB_BITS;    // product register
  localparam int DEC_BITS = 4 * AXIS_BITS + 8;    // decision, two's complement

  // Action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_SQB,
    ST_LD_AY,
    ST_LD_DEC,
    ST_EMIT,
    ST_ADV_POS,
    ST_ADV_DEC,
    ST_ENT1,
    ST_ENT2,
    ST_ENT3,
    ST_ENT4,
    ST_ENT5,
    ST_ENT6
  } mer_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,     // latch centre/colour, a^2, point to (0,b)
    OP_SQ_B,     // b^2
    OP_AY,       // a^2*b
    OP_INIT_D,   // initial decision
    OP_EMIT,     // write result register
    OP_POS,      // advance x/y
    OP_DEC,      // update decision
    OP_E1,       // region 2 entry sequence
    OP_E2,
    OP_E3,
    OP_E4,
    OP_E5,
    OP_E6
  } mer_op_t;

  typedef struct packed {
    logic out_free;     // result register can take a beat this cycle
    logic y_zero;       // current point is the last one
    logic need_entry;   // region 1 has ended, region 2 decision not yet set up
  } mer_status_t;

endpackage

// ----- rtl/mer_cmd_if.sv -----
// ----------------------------------------------------------------------------
// mer_cmd_if - command channel of the ellipse rasteriser
// valid/ready channel carrying a load or step command.
// ----------------------------------------------------------------------------
interface mer_cmd_if import mer_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [AXIS_BITS-1:0]  semi_axis_x;
  logic [AXIS_BITS-1:0]  semi_axis_y;
  logic [COLOR_BITS-1:0] color;

  modport source (
    output valid, action, center_x, center_y, semi_axis_x, semi_axis_y, color,
    input  ready
  );

  modport sink (
    input  valid, action, center_x, center_y, semi_axis_x, semi_axis_y, color,
    output ready
  );
endinterface

// ----- rtl/mer_pix_if.sv -----
// ----------------------------------------------------------------------------
// mer_pix_if - pixel channel of the ellipse rasteriser
// valid/ready channel carrying four mirrored coordinates and a colour.
// ----------------------------------------------------------------------------
interface mer_pix_if import mer_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] px_right_low;
  logic signed [OUT_BITS-1:0] px_left;
  logic signed [OUT_BITS-1:0] py_below;
  logic signed [OUT_BITS-1:0] py_above;
  logic [COLOR_BITS-1:0]      pixel_color;
  logic                       last_point;

  modport source (
    output valid, px_right_low, px_left, py_below, py_above, pixel_color,
           last_point,
    input  ready
  );

  modport sink (
    input  valid, px_right_low, px_left, py_below, py_above, pixel_color,
           last_point,
    output ready
  );
endinterface

// ----- rtl/mer_ctrl.sv -----
// ----------------------------------------------------------------------------
// mer_ctrl - sequencer of the ellipse rasteriser
// Accepts command beats, tracks whether an outline is running and steps the
// datapath through load, emit, advance and region 2 set-up sequences.
// ----------------------------------------------------------------------------
module mer_ctrl import mer_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mer_cmd_if.sink     cmd,
  input  mer_status_t status,
  output mer_op_t     op
);

  mer_state_t state, state_next;
  logic       active, active_next;
  logic       cmd_ready;

  assign cmd.ready = cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      active <= 1'b0;
    end else begin
      state  <= state_next;
      active <= active_next;
    end
  end

  always_comb begin
    state_next  = state;
    active_next = active;
    op          = OP_NONE;
    cmd_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd.valid) begin
          if (cmd.action == ACT_LOAD) begin
            op          = OP_LOAD;
            active_next = 1'b1;
            state_next  = ST_LD_SQB;
          end else if (active) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_LD_SQB: begin
        op         = OP_SQ_B;
        state_next = ST_LD_AY;
      end
      ST_LD_AY: begin
        op         = OP_AY;
        state_next = ST_LD_DEC;
      end
      ST_LD_DEC: begin
        op         = OP_INIT_D;
        state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          op = OP_EMIT;
          if (status.y_zero) begin
            active_next = 1'b0;
            state_next  = ST_IDLE;
          end else begin
            state_next = ST_ADV_POS;
          end
        end
      end
      ST_ADV_POS: begin
        if (status.need_entry) begin
          state_next = ST_ENT1;
        end else begin
          op         = OP_POS;
          state_next = ST_ADV_DEC;
        end
      end
      ST_ADV_DEC: begin
        op         = OP_DEC;
        state_next = ST_IDLE;
      end
      ST_ENT1: begin
        op         = OP_E1;
        state_next = ST_ENT2;
      end
      ST_ENT2: begin
        op         = OP_E2;
        state_next = ST_ENT3;
      end
      ST_ENT3: begin
        op         = OP_E3;
        state_next = ST_ENT4;
      end
      ST_ENT4: begin
        op         = OP_E4;
        state_next = ST_ENT5;
      end
      ST_ENT5: begin
        op         = OP_E5;
        state_next = ST_ENT6;
      end
      ST_ENT6: begin
        op         = OP_E6;
        state_next = ST_ADV_POS;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_step_emits: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && cmd.action == ACT_STEP && active)
      |=> (state == ST_EMIT))
    else $error("step on running outline did not reach emit");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && cmd.action == ACT_LOAD)
      |=> (active && state == ST_LD_SQB))
    else $error("load did not start an outline");

  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !status.out_free) |=> (state == ST_EMIT))
    else $error("emit left while result register full");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (op == OP_EMIT && status.y_zero) |=> !active)
    else $error("outline still running after last point");
`endif

endmodule

// ----- rtl/mer_dp.sv -----
// ----------------------------------------------------------------------------
// mer_dp - datapath of the ellipse rasteriser
// Holds the ellipse and point state, one shared multiplier with a product
// register, the decision adder and the result register.
// ----------------------------------------------------------------------------
module mer_dp import mer_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  mer_op_t               op,
  output mer_status_t           status,
  input  logic [COORD_BITS-1:0] center_x,
  input  logic [COORD_BITS-1:0] center_y,
  input  logic [AXIS_BITS-1:0]  semi_axis_x,
  input  logic [AXIS_BITS-1:0]  semi_axis_y,
  input  logic [COLOR_BITS-1:0] color,
  mer_pix_if.source             pix
);

  // ellipse parameters
  logic [COORD_BITS-1:0] origin_x, origin_y;
  logic [COLOR_BITS-1:0] held_color;
  logic [SQ_BITS-1:0]    a_squared, b_squared;

  // point state; bx = b^2*x and ay = a^2*y tracked incrementally
  logic [X_BITS-1:0]     point_x;
  logic [Y_BITS-1:0]     point_y;
  logic [XY_BITS-1:0]    bx, ay;
  logic [DEC_BITS-1:0]   decision;
  logic                  in_region_two;
  logic                  x_inc, y_dec;

  // shared multiplier
  logic [MA_BITS-1:0]    mul_a;
  logic [MB_BITS-1:0]    mul_b;
  logic [P_BITS-1:0]     prod, prod_q;

  // result register
  logic                       out_valid;
  logic signed [OUT_BITS-1:0] out_right, out_left, out_below, out_above;
  logic [COLOR_BITS-1:0]      out_color;
  logic                       out_last;

  logic [TX_BITS-1:0]    tx;
  logic [Y_BITS-1:0]     ty;
  logic                  dec_neg, dec_pos;
  logic                  step_x, step_y;

  assign tx      = {point_x, 1'b1};
  assign ty      = point_y - 1'b1;
  assign dec_neg = decision[DEC_BITS-1];
  assign dec_pos = !dec_neg && (decision != '0);

  // region 1: x always moves, y on a non-negative decision
  // region 2: y always moves, x on a non-positive decision
  assign step_x = in_region_two ? !dec_pos : 1'b1;
  assign step_y = in_region_two ? 1'b1 : !dec_neg;

  assign status.out_free   = !out_valid || pix.ready;
  assign status.y_zero     = (point_y == '0);
  assign status.need_entry = !in_region_two && !(bx < ay);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_LOAD: begin
        mul_a = MA_BITS'(semi_axis_x);
        mul_b = MB_BITS'(semi_axis_x);
      end
      OP_SQ_B: begin
        mul_a = MA_BITS'(point_y);
        mul_b = MB_BITS'(point_y);
      end
      OP_AY: begin
        mul_a = MA_BITS'(a_squared);
        mul_b = MB_BITS'(point_y);
      end
      OP_E1: begin
        mul_a = MA_BITS'(b_squared);
        mul_b = MB_BITS'(tx);
      end
      OP_E2: begin
        mul_a = prod_q[MA_BITS-1:0];
        mul_b = MB_BITS'(tx);
      end
      OP_E3: begin
        mul_a = MA_BITS'(a_squared);
        mul_b = MB_BITS'(ty);
      end
      OP_E4: begin
        mul_a = prod_q[MA_BITS-1:0];
        mul_b = MB_BITS'(ty);
      end
      OP_E5: begin
        mul_a = MA_BITS'(a_squared);
        mul_b = MB_BITS'(b_squared);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // control flops
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      in_region_two <= 1'b0;
    end else begin
      if (op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
      if (op == OP_LOAD) begin
        in_region_two <= 1'b0;
      end else if (op == OP_E6) begin
        in_region_two <= 1'b1;
      end
    end
  end

  // payload flops
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        origin_x   <= center_x;
        origin_y   <= center_y;
        held_color <= color;
        a_squared  <= SQ_BITS'(prod);
        point_x    <= '0;
        point_y    <= Y_BITS'(semi_axis_y);
        bx         <= '0;
      end
      OP_SQ_B: begin
        b_squared <= SQ_BITS'(prod);
      end
      OP_AY: begin
        prod_q <= prod;
      end
      OP_INIT_D: begin
        ay       <= XY_BITS'(prod_q);
        decision <= (DEC_BITS'(b_squared) << 2) - (DEC_BITS'(prod_q) << 2)
                    + DEC_BITS'(a_squared);
      end
      OP_EMIT: begin
        out_right <= OUT_BITS'(origin_x) + OUT_BITS'(point_x);
        out_left  <= OUT_BITS'(origin_x) - OUT_BITS'(point_x);
        out_below <= OUT_BITS'(origin_y) + OUT_BITS'(point_y);
        out_above <= OUT_BITS'(origin_y) - OUT_BITS'(point_y);
        out_color <= held_color;
        out_last  <= (point_y == '0);
      end
      OP_POS: begin
        if (step_x) begin
          point_x <= point_x + 1'b1;
          bx      <= bx + XY_BITS'(b_squared);
        end
        if (step_y) begin
          point_y <= point_y - 1'b1;
          ay      <= ay - XY_BITS'(a_squared);
        end
        x_inc <= step_x;
        y_dec <= step_y;
      end
      OP_DEC: begin
        decision <= decision
                    + (x_inc ? (DEC_BITS'(bx) << 3) : '0)
                    - (y_dec ? (DEC_BITS'(ay) << 3) : '0)
                    + (in_region_two ? (DEC_BITS'(a_squared) << 2)
                                     : (DEC_BITS'(b_squared) << 2));
      end
      OP_E1, OP_E2, OP_E4: begin
        prod_q <= prod;
      end
      OP_E3: begin
        decision <= DEC_BITS'(prod_q);           // b^2 (2x+1)^2
        prod_q   <= prod;
      end
      OP_E5: begin
        decision <= decision + (DEC_BITS'(prod_q) << 2);  // + 4a^2 (y-1)^2
        prod_q   <= prod;
      end
      OP_E6: begin
        decision <= decision - (DEC_BITS'(prod_q) << 2);  // - 4a^2 b^2
      end
      default: begin
      end
    endcase
  end

  assign pix.valid        = out_valid;
  assign pix.px_right_low = out_right;
  assign pix.px_left      = out_left;
  assign pix.py_below     = out_below;
  assign pix.py_above     = out_above;
  assign pix.pixel_color  = out_color;
  assign pix.last_point   = out_last;

`ifndef ASSERT_OFF
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (op == OP_EMIT) |-> (!out_valid || pix.ready))
    else $error("result overwritten before it was taken");

  a_region_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(in_region_two) |-> ($past(rst) || $past(op) == OP_LOAD))
    else $error("left region 2 without a load");
`endif

endmodule

// ----- rtl/midpoint_ellipse_rasterizer.sv -----
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer - axis-aligned ellipse outline generator
// Integer midpoint scheme, one outline point per step command, mirrored
// into the four quadrants around the centre.
// ----------------------------------------------------------------------------
// cmd : valid/ready command beats. action = load latches centre, semi-axes
//       and colour and places the point at (0, b); it yields no pixel beat.
//       action = step emits the current point and advances it. Steps with
//       no outline running are accepted and dropped.
// pix : valid/ready pixel beats, four mirrored coordinates (wrapped to
//       12 bits), the colour and a last flag on the point with y = 0.
// Timing: a load runs through accept, b^2, a^2*b and initial decision on the
//   one shared multiplier; a step runs through accept, emit, position, decision.
//   The first step of region 2 adds a pass through the position state and the
//   entry states ST_ENT1 to ST_ENT6, which set up its decision. A pixel beat is
//   valid after the emit state that follows its step loads the result register.
// Reset: rst clears the sequencer and the result register; no outline runs.
// Stall: the result register parts the channels; a pending pixel beat only
//   holds the next emit, and commands wait while that emit waits.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer import mer_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mer_cmd_if.sink   cmd,
  mer_pix_if.source pix
);

  mer_op_t     op;
  mer_status_t status;

  // sequencer: owns the command handshake and the running flag
  mer_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .op     (op)
  );

  // datapath: load fields are sampled in the accept cycle of a load
  mer_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .status      (status),
    .center_x    (cmd.center_x),
    .center_y    (cmd.center_y),
    .semi_axis_x (cmd.semi_axis_x),
    .semi_axis_y (cmd.semi_axis_y),
    .color       (cmd.color),
    .pix         (pix)
  );

endmodule
